/* rtl/sfa_pkg.sv */
`default_nettype none
package sfa_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_W      = 31;
    localparam int ACC_W      = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int PROD_W     = MAG_W + CFG_W;
    localparam int QUO_W      = CFG_W;
    localparam int E2_W       = 2 * QUO_W;
    localparam int E2SUM_W    = E2_W + 2;
    localparam int TRY_W      = SUM_W + 2;
    localparam int DTRY_W     = PROD_W + 2;
    localparam int SBIT_W     = $clog2(ROOT_W);
    localparam int DBIT_W     = $clog2(QUO_W);
    localparam int SQRT_CELLS = ROOT_W;
    localparam int DIV_CELLS  = QUO_W;

    typedef enum logic [1:0] {
        MODE_SEEK   = 2'd0,
        MODE_FLEE   = 2'd1,
        MODE_ARRIVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_MAXACC = 2'd1,
        REG_RADIUS = 2'd2,
        REG_INVT   = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        SEL_ZERO   = 2'd0,
        SEL_DIRECT = 2'd1,
        SEL_NORM   = 2'd2
    } t_sel;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CFG_W-1:0] maxacc;
        logic [CFG_W-1:0] radius;
        logic [CFG_W-1:0] invt;
    } t_cfg;

    typedef struct packed {
        logic                         vld;
        logic [2:0]                   neg;
        t_sel                         sel;
        logic                         in_radius;
        logic [SUM_W-1:0]             rem;
        logic [ROOT_W-1:0]            root;
        logic [2:0][PROD_W-1:0]       num;
        logic [2:0][QUO_W-1:0]        quo;
    } t_item;

endpackage
`default_nettype wire

/* rtl/sfa_ifs.sv */
`default_nettype none
interface sfa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfa_pkg::COORD_BITS-1:0] target_x;
    logic signed [sfa_pkg::COORD_BITS-1:0] target_y;
    logic signed [sfa_pkg::COORD_BITS-1:0] target_z;
    logic signed [sfa_pkg::COORD_BITS-1:0] agent_x;
    logic signed [sfa_pkg::COORD_BITS-1:0] agent_y;
    logic signed [sfa_pkg::COORD_BITS-1:0] agent_z;
    modport source (output valid, target_x, target_y, target_z, agent_x, agent_y, agent_z,
                    input ready);
    modport sink (input valid, target_x, target_y, target_z, agent_x, agent_y, agent_z,
                  output ready);
endinterface

interface sfa_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [sfa_pkg::ACC_W-1:0] accel_x;
    logic signed [sfa_pkg::ACC_W-1:0] accel_y;
    logic signed [sfa_pkg::ACC_W-1:0] accel_z;
    logic                             inside_radius;
    modport source (output valid, accel_x, accel_y, accel_z, inside_radius, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, inside_radius, output ready);
endinterface
`default_nettype wire

/* rtl/sfa_front.sv */
`default_nettype none
module sfa_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  sfa_pkg::t_cfg      i_cfg,
    sfa_in_if.sink             i_in,
    output sfa_pkg::t_item     o_item
);
    localparam int P  = sfa_pkg::PROD_W;
    localparam int F  = sfa_pkg::FRAC_BITS;
    localparam int Q  = sfa_pkg::QUO_W;
    localparam int R2 = 2 * sfa_pkg::CFG_W;

    logic signed [sfa_pkg::COORD_BITS-1:0] c_t [3];
    logic signed [sfa_pkg::COORD_BITS-1:0] c_a [3];
    logic [sfa_pkg::DIFF_W-1:0]            c_d [3];

    logic                           r1_vld;
    logic [2:0]                     r1_neg;
    logic [sfa_pkg::MAG_W-1:0]      r1_ad [3];
    logic [sfa_pkg::MAG_W-1:0]      n1_ad [3];
    logic [2:0]                     n1_neg;

    logic                           r2_vld;
    logic [2:0]                     r2_neg;
    logic [sfa_pkg::SQ_W-1:0]       r2_sq [3];
    logic [P-1:0]                   r2_pe [3];
    logic [P-1:0]                   r2_pn [3];

    logic                           r3_vld;
    logic [2:0]                     r3_neg;
    logic [sfa_pkg::SUM_W-1:0]      r3_s;
    logic [Q-1:0]                   r3_e [3];
    logic                           r3_big;
    logic [P-1:0]                   r3_pn [3];
    logic [sfa_pkg::SUM_W-1:0]      n3_s;
    logic                           n3_big;

    logic                           r4_vld;
    logic [2:0]                     r4_neg;
    logic [sfa_pkg::SUM_W-1:0]      r4_s;
    logic [Q-1:0]                   r4_e [3];
    logic [sfa_pkg::E2_W-1:0]       r4_e2 [3];
    logic                           r4_big;
    logic                           r4_lt;
    logic [P-1:0]                   r4_pn [3];

    logic [R2-1:0]                  r_r2;
    logic [R2-1:0]                  r_ma2;

    logic [sfa_pkg::E2SUM_W-1:0]    c_e2sum;
    sfa_pkg::t_item                 r_item;
    sfa_pkg::t_item                 n_item;

    assign i_in.ready = i_adv;
    assign o_item     = r_item;

    assign c_t[0] = i_in.target_x;
    assign c_t[1] = i_in.target_y;
    assign c_t[2] = i_in.target_z;
    assign c_a[0] = i_in.agent_x;
    assign c_a[1] = i_in.agent_y;
    assign c_a[2] = i_in.agent_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_d[i] = {c_t[i][sfa_pkg::COORD_BITS-1], c_t[i]}
                   - {c_a[i][sfa_pkg::COORD_BITS-1], c_a[i]};
            if (i_cfg.mode == sfa_pkg::MODE_FLEE) begin
                c_d[i] = -c_d[i];
            end
            n1_neg[i] = c_d[i][sfa_pkg::DIFF_W-1];
            n1_ad[i]  = n1_neg[i] ? sfa_pkg::MAG_W'(-c_d[i]) : sfa_pkg::MAG_W'(c_d[i]);
        end
    end

    always_comb begin
        n3_s   = '0;
        n3_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n3_s = n3_s + sfa_pkg::SUM_W'(r2_sq[i]);
            if (r2_pe[i][P-1:F+Q] != '0) begin
                n3_big = 1'b1;
            end
        end
    end

    assign c_e2sum = sfa_pkg::E2SUM_W'(r4_e2[0]) + sfa_pkg::E2SUM_W'(r4_e2[1])
                   + sfa_pkg::E2SUM_W'(r4_e2[2]);

    always_comb begin
        n_item           = '0;
        n_item.vld       = r4_vld;
        n_item.neg       = r4_neg;
        n_item.rem       = r4_s;
        n_item.sel       = sfa_pkg::SEL_ZERO;
        n_item.in_radius = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_item.num[i] = r4_pn[i];
            n_item.quo[i] = r4_e[i];
        end
        unique case (i_cfg.mode)
            sfa_pkg::MODE_SEEK, sfa_pkg::MODE_FLEE: begin
                n_item.sel = (r4_s != '0) ? sfa_pkg::SEL_NORM : sfa_pkg::SEL_ZERO;
            end
            sfa_pkg::MODE_ARRIVE: begin
                if (r4_lt) begin
                    n_item.in_radius = 1'b1;
                end else if (r4_big || c_e2sum > sfa_pkg::E2SUM_W'(r_ma2)) begin
                    n_item.sel = sfa_pkg::SEL_NORM;
                end else begin
                    n_item.sel = sfa_pkg::SEL_DIRECT;
                end
            end
            default: begin
                n_item.sel = sfa_pkg::SEL_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_r2  <= R2'(i_cfg.radius) * R2'(i_cfg.radius);
        r_ma2 <= R2'(i_cfg.maxacc) * R2'(i_cfg.maxacc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r4_vld     <= 1'b0;
            r_item.vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_neg <= n1_neg;
            r2_neg <= r1_neg;
            r3_neg <= r2_neg;
            r4_neg <= r3_neg;
            r3_s   <= n3_s;
            r3_big <= n3_big;
            r4_s   <= r3_s;
            r4_big <= r3_big;
            r4_lt  <= r3_s < sfa_pkg::SUM_W'(r_r2);
            for (int i = 0; i < 3; i++) begin
                r1_ad[i] <= n1_ad[i];
                r2_sq[i] <= sfa_pkg::SQ_W'(r1_ad[i]) * sfa_pkg::SQ_W'(r1_ad[i]);
                r2_pe[i] <= P'(r1_ad[i]) * P'(i_cfg.invt);
                r2_pn[i] <= P'(r1_ad[i]) * P'(i_cfg.maxacc);
                r3_e[i]  <= r2_pe[i][F+Q-1:F];
                r3_pn[i] <= r2_pn[i];
                r4_e[i]  <= r3_e[i];
                r4_e2[i] <= sfa_pkg::E2_W'(r3_e[i]) * sfa_pkg::E2_W'(r3_e[i]);
                r4_pn[i] <= r3_pn[i];
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/sfa_sqrt_cell.sv */
`default_nettype none
module sfa_sqrt_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [sfa_pkg::SBIT_W-1:0] i_bit,
    input  sfa_pkg::t_item                  i_item,
    output sfa_pkg::t_item                  o_item
);
    localparam int T = sfa_pkg::TRY_W;

    logic [T-1:0]   c_try;
    logic           c_take;
    sfa_pkg::t_item r_item;
    sfa_pkg::t_item n_item;

    assign o_item = r_item;

    always_comb begin
        c_try  = (T'(i_item.root) << (T'(i_bit) + T'(1))) | (T'(1) << (T'(i_bit) << 1));
        c_take = c_try <= T'(i_item.rem);
        n_item = i_item;
        if (c_take) begin
            n_item.rem  = i_item.rem - sfa_pkg::SUM_W'(c_try);
            n_item.root = i_item.root | (sfa_pkg::ROOT_W'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_adv) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

/* rtl/sfa_div_cell.sv */
`default_nettype none
module sfa_div_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [sfa_pkg::DBIT_W-1:0] i_bit,
    input  sfa_pkg::t_item                  i_item,
    output sfa_pkg::t_item                  o_item
);
    localparam int T = sfa_pkg::DTRY_W;

    logic [T-1:0]   c_try;
    logic           c_take;
    sfa_pkg::t_item r_item;
    sfa_pkg::t_item n_item;

    assign o_item = r_item;

    always_comb begin
        c_try  = T'(i_item.root) << i_bit;
        n_item = i_item;
        c_take = 1'b0;
        if (i_item.sel == sfa_pkg::SEL_NORM) begin
            for (int i = 0; i < 3; i++) begin
                c_take = c_try <= T'(i_item.num[i]);
                n_item.quo[i][i_bit] = c_take;
                if (c_take) begin
                    n_item.num[i] = i_item.num[i] - sfa_pkg::PROD_W'(c_try);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_adv) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

/* rtl/seek_flee_arrive_steering.sv */
// Channel   Dir  Word
// i_in      in   target_x/y/z, agent_x/y/z, signed Q15.16
// o_out     out  accel_x/y/z signed Q15.16, inside_radius
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// A new word is taken every cycle while the output is not stalled. The chain runs
// through the front stages, the square-root cells (one root bit each) and the divide
// cells (one quotient bit each, three lanes in parallel).
// A stall on the output freezes the whole chain; words are never dropped.
// Reset is synchronous and clears only the valid bits and the configuration registers.
`default_nettype none
module seek_flee_arrive_steering (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_W-1:0] i_cfg_data,
    sfa_in_if.sink                         i_in,
    sfa_out_if.source                      o_out
);
    localparam int SC = sfa_pkg::SQRT_CELLS;
    localparam int DC = sfa_pkg::DIV_CELLS;

    sfa_pkg::t_cfg  r_cfg;
    sfa_pkg::t_item c_sq [SC+1];
    sfa_pkg::t_item c_dv [DC+1];
    sfa_pkg::t_item c_last;
    logic           c_adv;
    logic [sfa_pkg::QUO_W-1:0] c_mag [3];
    logic [sfa_pkg::ACC_W-1:0] c_acc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= sfa_pkg::MODE_SEEK;
            r_cfg.maxacc <= sfa_pkg::CFG_W'(1) << sfa_pkg::FRAC_BITS;
            r_cfg.radius <= sfa_pkg::CFG_W'(1) << sfa_pkg::FRAC_BITS;
            r_cfg.invt   <= sfa_pkg::CFG_W'(1) << sfa_pkg::FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfa_pkg::REG_MODE:   r_cfg.mode   <= i_cfg_data[1:0];
                sfa_pkg::REG_MAXACC: r_cfg.maxacc <= i_cfg_data;
                sfa_pkg::REG_RADIUS: r_cfg.radius <= i_cfg_data;
                sfa_pkg::REG_INVT:   r_cfg.invt   <= i_cfg_data;
                default:             r_cfg.invt   <= i_cfg_data;
            endcase
        end
    end

    assign c_adv = !c_last.vld || o_out.ready;

    sfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (c_adv),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_item  (c_sq[0])
    );

    for (genvar j = 0; j < SC; j++) begin : g_sqrt
        sfa_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (c_adv),
            .i_bit   (sfa_pkg::SBIT_W'(SC - 1 - j)),
            .i_item  (c_sq[j]),
            .o_item  (c_sq[j+1])
        );
    end

    assign c_dv[0] = c_sq[SC];

    for (genvar j = 0; j < DC; j++) begin : g_div
        sfa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (c_adv),
            .i_bit   (sfa_pkg::DBIT_W'(DC - 1 - j)),
            .i_item  (c_dv[j]),
            .o_item  (c_dv[j+1])
        );
    end

    assign c_last = c_dv[DC];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_mag[i] = (c_last.sel == sfa_pkg::SEL_ZERO) ? '0 : c_last.quo[i];
            c_acc[i] = c_last.neg[i] ? -sfa_pkg::ACC_W'(c_mag[i]) : sfa_pkg::ACC_W'(c_mag[i]);
        end
    end

    assign o_out.valid         = c_last.vld;
    assign o_out.accel_x       = c_acc[0];
    assign o_out.accel_y       = c_acc[1];
    assign o_out.accel_z       = c_acc[2];
    assign o_out.inside_radius = c_last.in_radius;

    a_inside_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.inside_radius |->
            o_out.accel_x == '0 && o_out.accel_y == '0 && o_out.accel_z == '0)
        else $error("inside radius with nonzero acceleration");

    a_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && c_last.sel == sfa_pkg::SEL_NORM |->
            c_mag[0] <= r_cfg.maxacc && c_mag[1] <= r_cfg.maxacc
            && c_mag[2] <= r_cfg.maxacc)
        else $error("normalized component exceeds max acceleration");

    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_stall_freeze : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !c_adv |=> $stable(c_sq[1]) && $stable(c_dv[1]))
        else $error("chain moved during stall");
endmodule
`default_nettype wire
